FILE: hdl/jcsr_pkg.sv
// Package: constants and types for the JPEG capture sector ring.
`default_nettype none
package jcsr_pkg;

  localparam int SECTOR_BYTES_DEF = 512;
  localparam int NUM_SECTORS_DEF  = 10;
  localparam int HEADER_BYTES_DEF = 14;

  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int SECNUM_W = 4;

  localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hFF;
  localparam logic [BYTE_W-1:0] MARK_EOI    = 8'hD9;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

endpackage
`default_nettype wire

FILE: hdl/jpeg_capture_sector_ring.sv
// Top level: camera byte capture into a header area and a ring of sectors.
// The result is registered on input accept and is valid in the cycle after.
// One item per cycle while out_ready is high; the result register frees in the cycle it is taken.
// Status outputs (done_index, pending_flags, header_mode) show state after the item.
// Reset: header mode, pointer 0, previous byte 0, flags clear, last full sector 0.
`default_nettype none
module jpeg_capture_sector_ring #(
  parameter int SECTOR_BYTES = jcsr_pkg::SECTOR_BYTES_DEF,
  parameter int NUM_SECTORS  = jcsr_pkg::NUM_SECTORS_DEF,
  parameter int HEADER_BYTES = jcsr_pkg::HEADER_BYTES_DEF,
  parameter int PTR_W        = $clog2(SECTOR_BYTES * NUM_SECTORS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [jcsr_pkg::KIND_W-1:0]   kind,
  input  wire logic [jcsr_pkg::BYTE_W-1:0]   rx_byte,
  input  wire logic [jcsr_pkg::SECNUM_W-1:0] ack_sector,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               buf_write,
  output logic [PTR_W-1:0]                   buf_addr,
  output logic [jcsr_pkg::BYTE_W-1:0]        buf_data,
  output logic                               sector_done,
  output logic [jcsr_pkg::SECNUM_W-1:0]      done_index,
  output logic                               end_of_image,
  output logic [NUM_SECTORS-1:0]             pending_flags,
  output logic                               header_mode
);
  import jcsr_pkg::*;

  localparam int OFF_W = $clog2(SECTOR_BYTES);
  localparam int SEC_W = $clog2(NUM_SECTORS);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SECTOR_BYTES - 1);
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(NUM_SECTORS - 1);

  logic                   in_header, in_header_next;
  logic [PTR_W-1:0]       ptr, ptr_next;
  logic [OFF_W-1:0]       off, off_next;
  logic [SEC_W-1:0]       sec, sec_next;
  logic [BYTE_W-1:0]      prev, prev_next;
  logic [NUM_SECTORS-1:0] flags, flags_next;
  logic [SEC_W-1:0]       last_sec, last_sec_next;

  logic                   wr_next, sdone_next, eoi_next;
  logic [PTR_W-1:0]       addr_next;
  logic [BYTE_W-1:0]      data_next;

  logic                   accept;
  logic                   ptr_last;
  logic [PTR_W:0]         ptr_inc;
  logic                   hdr_hit;
  logic [PTR_W-1:0]       ptr_adv;
  logic [OFF_W-1:0]       off_adv;
  logic [SEC_W-1:0]       sec_adv;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // ring advance, tracked as pointer plus sector/offset pair
  assign ptr_last = (sec == SEC_LAST) && (off == OFF_LAST);
  assign ptr_inc  = {1'b0, ptr} + (PTR_W+1)'(1);
  assign hdr_hit  = (32'(ptr_inc) == 32'(HEADER_BYTES));
  assign ptr_adv  = ptr_last ? '0 : ptr_inc[PTR_W-1:0];
  assign off_adv  = (off == OFF_LAST) ? '0 : off + OFF_W'(1);
  assign sec_adv  = (off != OFF_LAST) ? sec : ((sec == SEC_LAST) ? '0 : sec + SEC_W'(1));

  always_comb begin
    in_header_next = in_header;
    ptr_next       = ptr;
    off_next       = off;
    sec_next       = sec;
    prev_next      = prev;
    flags_next     = flags;
    last_sec_next  = last_sec;
    wr_next        = 1'b0;
    addr_next      = '0;
    data_next      = '0;
    sdone_next     = 1'b0;
    eoi_next       = 1'b0;
    case (kind)
      KIND_BYTE: begin
        wr_next   = 1'b1;
        addr_next = ptr;
        data_next = rx_byte;
        if (in_header) begin
          if (hdr_hit) begin
            in_header_next = 1'b0;
            ptr_next       = '0;
            off_next       = '0;
            sec_next       = '0;
          end else begin
            ptr_next = ptr_adv;
            off_next = off_adv;
            sec_next = sec_adv;
          end
        end else if (rx_byte == MARK_EOI && prev == MARK_PREFIX) begin
          eoi_next       = 1'b1;
          in_header_next = 1'b1;
          ptr_next       = ptr_adv;
          off_next       = off_adv;
          sec_next       = sec_adv;
        end else begin
          if (off == OFF_LAST) begin
            flags_next    = flags | (NUM_SECTORS'(1) << sec);
            last_sec_next = sec;
            sdone_next    = 1'b1;
          end
          ptr_next  = ptr_adv;
          off_next  = off_adv;
          sec_next  = sec_adv;
          prev_next = rx_byte;
        end
      end
      KIND_ACK: begin
        if (32'(ack_sector) < 32'(NUM_SECTORS)) begin
          flags_next = flags & ~(NUM_SECTORS'(1) << ack_sector);
        end
      end
      KIND_RESTART: begin
        ptr_next       = '0;
        off_next       = '0;
        sec_next       = '0;
        flags_next     = '0;
        prev_next      = '0;
        in_header_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header <= 1'b1;
      ptr       <= '0;
      off       <= '0;
      sec       <= '0;
      prev      <= '0;
      flags     <= '0;
      last_sec  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_header <= in_header_next;
        ptr       <= ptr_next;
        off       <= off_next;
        sec       <= sec_next;
        prev      <= prev_next;
        flags     <= flags_next;
        last_sec  <= last_sec_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_write    <= wr_next;
      buf_addr     <= addr_next;
      buf_data     <= data_next;
      sector_done  <= sdone_next;
      end_of_image <= eoi_next;
    end
  end

  // state only changes on accept, so it stays in step with the held result
  assign done_index    = SECNUM_W'(last_sec);
  assign pending_flags = flags;
  assign header_mode   = in_header;

endmodule
`default_nettype wire
